[rtl/mdng_pkg.sv]
package mdng_pkg;

	localparam int unsigned GAIN_WIDTH  = 8;
	localparam int unsigned WHEEL_WIDTH = 5;

	localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 8'd1;

	// gate: both magnitudes below GATE_LIMIT and step at most GATE_MARGIN
	localparam int GATE_LIMIT  = 5;
	localparam int GATE_MARGIN = 3;

	// wheel: z*10 clamped to +-50 then *30/100 reduces to 3*clamp(z,-5,5)
	localparam int WHEEL_IN_LIMIT = 5;
	localparam int WHEEL_SCALE    = 3;

	typedef logic signed [WHEEL_WIDTH-1:0] wheel_t;
	typedef logic [GAIN_WIDTH-1:0]         gain_t;

endpackage

[rtl/motion_delta_noise_gate_unit.sv]
// An accepted item passes through the input register and then the result register before out_valid rises.
// Throughput: one item per cycle while out_ready is high; the ready chain runs from out_ready through both stages.
// Multiplier: one SAMPLE_WIDTH x 9 bit signed product for x and for y in the result stage.
// Reset (arst_n low, asynchronous): pipeline empty, previous sample zero, dpi_gain one.
module motion_delta_noise_gate_unit #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           dpi_gain_we,
	input  mdng_pkg::gain_t                dpi_gain_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] motion_x,
	input  logic signed [SAMPLE_WIDTH-1:0] motion_y,
	input  logic signed [SAMPLE_WIDTH-1:0] motion_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] out_x,
	output logic signed [SAMPLE_WIDTH-1:0] out_y,
	output mdng_pkg::wheel_t               out_wheel
);
	import mdng_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH + 1;

	localparam logic signed [SW-1:0] G_HI   = SW'(GATE_LIMIT - 1);
	localparam logic signed [SW-1:0] G_LO   = -SW'(GATE_LIMIT - 1);
	localparam logic signed [SW:0]   D_HI   = (SW+1)'(GATE_MARGIN);
	localparam logic signed [SW:0]   D_LO   = -(SW+1)'(GATE_MARGIN);
	localparam logic signed [SW-1:0] MARGIN = SW'(GATE_MARGIN);
	localparam logic signed [SW-1:0] Z_HI   = SW'(WHEEL_IN_LIMIT);
	localparam logic signed [SW-1:0] Z_LO   = -SW'(WHEEL_IN_LIMIT);
	localparam logic signed [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};

	function automatic logic signed [SW-1:0] gate_shrink(
		input logic signed [SW-1:0] cur,
		input logic signed [SW-1:0] prev
	);
		logic signed [SW:0]   d;
		logic signed [SW-1:0] v;
		d = (SW+1)'(cur) - (SW+1)'(prev);
		v = cur;
		if (cur <= G_HI && cur >= G_LO && prev <= G_HI && prev >= G_LO &&
		    d <= D_HI && d >= D_LO) begin
			v = '0;
		end
		if (v > 0) begin
			v = v - MARGIN;
		end else if (v < 0) begin
			v = v + MARGIN;
		end
		return v;
	endfunction

	function automatic logic signed [SW-1:0] gain_sat(
		input logic signed [SW-1:0] f,
		input gain_t                g
	);
		logic signed [PW-1:0] p;
		logic                 all1;
		logic                 any1;
		p    = PW'(f) * PW'($signed({1'b0, g}));
		all1 = &p[PW-1:SW-1];
		any1 = |p[PW-1:SW-1];
		if (!p[PW-1] && any1) begin
			return S_MAX;
		end else if (p[PW-1] && !all1) begin
			return S_MIN;
		end
		return p[SW-1:0];
	endfunction

	gain_t                gain_q;
	logic signed [SW-1:0] prev_x_q, prev_y_q, prev_z_q;

	logic                 valid_s1;
	logic signed [SW-1:0] cur_x_s1, cur_y_s1, cur_z_s1;
	logic signed [SW-1:0] prv_x_s1, prv_y_s1, prv_z_s1;

	logic                 valid_s2;
	logic signed [SW-1:0] out_x_s2, out_y_s2;
	wheel_t               wheel_s2;

	logic                 ready_s2;
	logic                 in_acc;
	logic                 adv_s1;
	logic signed [SW-1:0] fx, fy, fz, zc;
	wheel_t               zw;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign in_acc   = in_valid && in_ready;
	assign adv_s1   = valid_s1 && ready_s2;

	always_comb begin
		fx = gate_shrink(cur_x_s1, prv_x_s1);
		fy = gate_shrink(cur_y_s1, prv_y_s1);
		fz = gate_shrink(cur_z_s1, prv_z_s1);
		if (fz > Z_HI) begin
			zc = Z_HI;
		end else if (fz < Z_LO) begin
			zc = Z_LO;
		end else begin
			zc = fz;
		end
		zw = WHEEL_WIDTH'(zc) * WHEEL_WIDTH'(WHEEL_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (dpi_gain_we) begin
				gain_q <= dpi_gain_wdata;
			end
			if (in_acc) begin
				prev_x_q <= motion_x;
				prev_y_q <= motion_y;
				prev_z_q <= motion_z;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_x_s1 <= motion_x;
			cur_y_s1 <= motion_y;
			cur_z_s1 <= motion_z;
			prv_x_s1 <= prev_x_q;
			prv_y_s1 <= prev_y_q;
			prv_z_s1 <= prev_z_q;
		end
		if (adv_s1) begin
			out_x_s2 <= gain_sat(fx, gain_q);
			out_y_s2 <= gain_sat(fy, gain_q);
			wheel_s2 <= zw;
		end
	end

	assign out_valid = valid_s2;
	assign out_x     = out_x_s2;
	assign out_y     = out_y_s2;
	assign out_wheel = wheel_s2;

	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted item did not reach input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(cur_x_s1) && $stable(prv_z_s1))
		else $error("input register changed while stalled");

	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_wheel <= 5'sd15 && out_wheel >= -5'sd15))
		else $error("wheel step out of range");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && gain_q == '0 |=> out_x == '0 && out_y == '0)
		else $error("zero gain gave nonzero x or y");

endmodule
